[rtl/rufp_pkg.sv]
// ----------------------------------------------------------------------------
// rufp_pkg - shared types and constants of the serial frame parser
// Parse phases, register indexes, reset values and the frame hand-off record.
// ----------------------------------------------------------------------------
package rufp_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] REG_HEADER_FIRST   = 2'd0;
	localparam logic [1:0] REG_HEADER_SECOND  = 2'd1;
	localparam logic [1:0] REG_TRAILER_FIRST  = 2'd2;
	localparam logic [1:0] REG_TRAILER_SECOND = 2'd3;

	localparam logic [7:0] HEADER_FIRST_RST   = 8'd83;
	localparam logic [7:0] HEADER_SECOND_RST  = 8'd89;
	localparam logic [7:0] TRAILER_FIRST_RST  = 8'd84;
	localparam logic [7:0] TRAILER_SECOND_RST = 8'd67;

	// heartbeat frame bytes from the control byte onward
	localparam logic [7:0] HB_CTRL   = 8'h01;
	localparam logic [7:0] HB_CMD    = 8'h01;
	localparam logic [7:0] HB_LEN_HI = 8'h00;
	localparam logic [7:0] HB_LEN_LO = 8'h01;
	localparam logic [7:0] HB_DATA   = 8'h0F;
	localparam logic [7:0] HB_SUM    = 8'hBE;
	localparam logic [7:0] HB_END1   = 8'h54;
	localparam logic [7:0] HB_END2   = 8'h43;

	// wide enough for lengths up to 127; the result fields hold depths up to 32
	localparam int LEN_W = 7;

	typedef enum logic [9:0] {
		PH_HUNT  = 10'b00_0000_0001,
		PH_HDR2  = 10'b00_0000_0010,
		PH_CTRL  = 10'b00_0000_0100,
		PH_CMD   = 10'b00_0000_1000,
		PH_LENHI = 10'b00_0001_0000,
		PH_LENLO = 10'b00_0010_0000,
		PH_DATA  = 10'b00_0100_0000,
		PH_SUM   = 10'b00_1000_0000,
		PH_END1  = 10'b01_0000_0000,
		PH_END2  = 10'b10_0000_0000
	} phase_t;

	// accepted frame, handed from parser to emitter
	typedef struct packed {
		logic             valid;
		logic [7:0]       ctrl;
		logic [7:0]       cmd;
		logic [LEN_W-1:0] len;
		logic             hb;
	} frame_t;

endpackage

[rtl/radar_uart_frame_parser.sv]
// ----------------------------------------------------------------------------
// radar_uart_frame_parser - serial frame parser with additive checksum
// Received bytes enter on the s_axis channel, one item per byte. Frames of
// the form H1 H2 CTRL CMD LEN_HI LEN_LO PAYLOAD SUM T1 T2 are checked and,
// when good, a run of result items leaves on m_axis: one per payload byte
// (tlast on the final one), or a single item with tuser[0] low for an empty
// frame. The cfg port sets the header and end bytes; write it only when idle.
// Input rate: one byte per cycle while no run is being sent. After the item
// that carries the second end byte, s_axis_tready stays low until the final
// result is loaded into the output register; for each result the single read
// port of the payload store takes an address and then returns registered
// data, and no new address is issued while that data is pending. The first
// result follows the final end byte through the store read and the output
// register. A stall on m_axis_tready holds it and pauses store reads; bytes are
// again accepted while the final result still waits in the output register.
// Reset (arst_n low) returns the parser to hunting for a header, loads the
// default header and end bytes and drops any run in flight. The store needs
// no clearing: an entry's data is only used after the same frame wrote it.
// ----------------------------------------------------------------------------
module radar_uart_frame_parser #(
	parameter int PAYLOAD_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// received byte stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] ctrl_code, [15:8] cmd_code, [21:16] payload_length,
	// [26:22] byte_index, [34:27] payload_byte, [39:35] zero
	output logic [39:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,   // [0] has_payload, [1] is_heartbeat
	output logic        m_axis_tlast,   // last_of_frame
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata
);

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam int LW = $clog2(PAYLOAD_DEPTH + 1);

	rufp_pkg::frame_t frame;
	logic          take, busy;
	logic          st_we, rd_en;
	logic [AW-1:0] st_waddr, rd_addr;
	logic [7:0]    st_wdata, rd_data;
	logic [7:0]    ctrl_code, cmd_code, payload_byte;
	logic [5:0]    payload_length;
	logic [4:0]    byte_index;
	logic          has_payload, is_heartbeat, last_of_frame;

	// no byte is taken while a run reads the store
	assign s_axis_tready = !busy;
	assign take          = s_axis_tvalid && s_axis_tready;

	rufp_parse #(
		.DEPTH(PAYLOAD_DEPTH),
		.AW   (AW),
		.LW   (LW)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.rx       (s_axis_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.st_we    (st_we),
		.st_waddr (st_waddr),
		.st_wdata (st_wdata),
		.frame    (frame)
	);

	rufp_store #(
		.DEPTH(PAYLOAD_DEPTH),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	rufp_emit #(
		.AW(AW),
		.LW(LW)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame         (frame),
		.busy          (busy),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.ctrl_code     (ctrl_code),
		.cmd_code      (cmd_code),
		.payload_length(payload_length),
		.byte_index    (byte_index),
		.payload_byte  (payload_byte),
		.has_payload   (has_payload),
		.is_heartbeat  (is_heartbeat),
		.last_of_frame (last_of_frame)
	);

	assign m_axis_tdata = {5'd0, payload_byte, byte_index, payload_length, cmd_code, ctrl_code};
	assign m_axis_tuser = {is_heartbeat, has_payload};
	assign m_axis_tlast = last_of_frame;

endmodule

[rtl/rufp_store.sv]
// ----------------------------------------------------------------------------
// rufp_store - payload store
// Single write port, single synchronous read port with registered read data.
// ----------------------------------------------------------------------------
module rufp_store #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/rufp_parse.sv]
// ----------------------------------------------------------------------------
// rufp_parse - byte-level frame parser
// Header/trailer match, running sum, heartbeat tracking, payload writes.
// ----------------------------------------------------------------------------
module rufp_parse #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int LW    = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          rx,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_addr,
	input  logic [7:0]          cfg_wdata,
	output logic                st_we,
	output logic [AW-1:0]       st_waddr,
	output logic [7:0]          st_wdata,
	output rufp_pkg::frame_t    frame
);

	rufp_pkg::phase_t phase_q, phase_n;
	logic [7:0]    hdr1_q, hdr2_q, trl1_q, trl2_q;
	logic [7:0]    ctrl_q, ctrl_n, cmd_q, cmd_n, len_hi_q, len_hi_n;
	logic [LW-1:0] len_q, len_n, cnt_q, cnt_n;
	logic [LW-1:0] cnt_inc;
	logic [7:0]    sum_q, sum_n, sum_add;
	logic          hb_q, hb_n;
	logic [15:0]   len16;

	assign sum_add  = sum_q + rx;
	assign len16    = {len_hi_q, rx};
	assign cnt_inc  = cnt_q + LW'(1);
	assign st_waddr = cnt_q[AW-1:0];
	assign st_wdata = rx;

	always_comb begin
		phase_n  = phase_q;
		ctrl_n   = ctrl_q;
		cmd_n    = cmd_q;
		len_hi_n = len_hi_q;
		len_n    = len_q;
		cnt_n    = cnt_q;
		sum_n    = sum_q;
		hb_n     = hb_q;
		st_we    = 1'b0;
		frame    = '0;
		frame.ctrl = ctrl_q;
		frame.cmd  = cmd_q;
		frame.len  = rufp_pkg::LEN_W'(len_q);
		unique case (phase_q)
			rufp_pkg::PH_HUNT: begin
				if (rx == hdr1_q) begin
					sum_n   = rx;
					hb_n    = 1'b1;
					phase_n = rufp_pkg::PH_HDR2;
				end
			end
			rufp_pkg::PH_HDR2: begin
				if (rx == hdr2_q) begin
					sum_n   = sum_add;
					phase_n = rufp_pkg::PH_CTRL;
				end else if (rx == hdr1_q) begin
					sum_n   = rx;
					hb_n    = 1'b1;
					phase_n = rufp_pkg::PH_HDR2;
				end else begin
					phase_n = rufp_pkg::PH_HUNT;
				end
			end
			rufp_pkg::PH_CTRL: begin
				if (rx != rufp_pkg::HB_CTRL) hb_n = 1'b0;
				ctrl_n  = rx;
				sum_n   = sum_add;
				phase_n = rufp_pkg::PH_CMD;
			end
			rufp_pkg::PH_CMD: begin
				if (rx != rufp_pkg::HB_CMD) hb_n = 1'b0;
				cmd_n   = rx;
				sum_n   = sum_add;
				phase_n = rufp_pkg::PH_LENHI;
			end
			rufp_pkg::PH_LENHI: begin
				if (rx != rufp_pkg::HB_LEN_HI) hb_n = 1'b0;
				len_hi_n = rx;
				sum_n    = sum_add;
				phase_n  = rufp_pkg::PH_LENLO;
			end
			rufp_pkg::PH_LENLO: begin
				if (rx != rufp_pkg::HB_LEN_LO) hb_n = 1'b0;
				len_n = len16[LW-1:0];
				sum_n = sum_add;
				cnt_n = '0;
				if (len16 == 16'd0) begin
					phase_n = rufp_pkg::PH_SUM;
				end else if (len16 <= 16'(DEPTH)) begin
					phase_n = rufp_pkg::PH_DATA;
				end else begin
					// too long for the store: drop
					phase_n = rufp_pkg::PH_HUNT;
				end
			end
			rufp_pkg::PH_DATA: begin
				if (rx != rufp_pkg::HB_DATA) hb_n = 1'b0;
				st_we = take;
				cnt_n = cnt_inc;
				sum_n = sum_add;
				if (cnt_inc >= len_q) phase_n = rufp_pkg::PH_SUM;
			end
			rufp_pkg::PH_SUM: begin
				if (rx != rufp_pkg::HB_SUM) hb_n = 1'b0;
				phase_n = (sum_q == rx) ? rufp_pkg::PH_END1 : rufp_pkg::PH_HUNT;
			end
			rufp_pkg::PH_END1: begin
				if (rx != rufp_pkg::HB_END1) hb_n = 1'b0;
				if (rx == trl1_q) begin
					phase_n = rufp_pkg::PH_END2;
				end else if (rx == hdr1_q) begin
					sum_n   = rx;
					hb_n    = 1'b1;
					phase_n = rufp_pkg::PH_HDR2;
				end else begin
					phase_n = rufp_pkg::PH_HUNT;
				end
			end
			rufp_pkg::PH_END2: begin
				if (rx != rufp_pkg::HB_END2) hb_n = 1'b0;
				frame.valid = take && (rx == trl2_q);
				phase_n     = rufp_pkg::PH_HUNT;
			end
			default: begin
				phase_n = rufp_pkg::PH_HUNT;
			end
		endcase
		frame.hb = hb_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rufp_pkg::PH_HUNT;
			ctrl_q   <= '0;
			cmd_q    <= '0;
			len_hi_q <= '0;
			len_q    <= '0;
			cnt_q    <= '0;
			sum_q    <= '0;
			hb_q     <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_n;
			ctrl_q   <= ctrl_n;
			cmd_q    <= cmd_n;
			len_hi_q <= len_hi_n;
			len_q    <= len_n;
			cnt_q    <= cnt_n;
			sum_q    <= sum_n;
			hb_q     <= hb_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr1_q <= rufp_pkg::HEADER_FIRST_RST;
			hdr2_q <= rufp_pkg::HEADER_SECOND_RST;
			trl1_q <= rufp_pkg::TRAILER_FIRST_RST;
			trl2_q <= rufp_pkg::TRAILER_SECOND_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				rufp_pkg::REG_HEADER_FIRST:   hdr1_q <= cfg_wdata;
				rufp_pkg::REG_HEADER_SECOND:  hdr2_q <= cfg_wdata;
				rufp_pkg::REG_TRAILER_FIRST:  trl1_q <= cfg_wdata;
				rufp_pkg::REG_TRAILER_SECOND: trl2_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

endmodule

[rtl/rufp_emit.sv]
// ----------------------------------------------------------------------------
// rufp_emit - result run generator
// Walks the payload store for an accepted frame; output register on the bus.
// ----------------------------------------------------------------------------
module rufp_emit #(
	parameter int AW = 5,
	parameter int LW = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rufp_pkg::frame_t frame,
	output logic             busy,
	output logic             rd_en,
	output logic [AW-1:0]    rd_addr,
	input  logic [7:0]       rd_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       ctrl_code,
	output logic [7:0]       cmd_code,
	output logic [5:0]       payload_length,
	output logic [4:0]       byte_index,
	output logic [7:0]       payload_byte,
	output logic             has_payload,
	output logic             is_heartbeat,
	output logic             last_of_frame
);

	logic          run_q, pend_q, empty_q, out_valid_q;
	logic [LW-1:0] idx_q, len_q;
	logic [7:0]    ctrl_q, cmd_q;
	logic          hb_q;
	logic [LW-1:0] pend_idx_s1;
	logic          pend_last_s1;
	logic [LW:0]   idx_nxt;
	logic          issue, at_last;
	logic [15:0]   len_w, idx_w;

	assign idx_nxt = {1'b0, idx_q} + (LW + 1)'(1);
	assign at_last = empty_q || (idx_nxt >= {1'b0, len_q});
	assign issue   = run_q && !pend_q && (!out_valid_q || out_ready);
	assign rd_en   = issue;
	assign rd_addr = idx_q[AW-1:0];
	assign busy    = run_q || pend_q;
	assign len_w   = 16'(len_q);
	assign idx_w   = 16'(pend_idx_s1);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (frame.valid) begin
				run_q <= 1'b1;
			end else if (issue && at_last) begin
				run_q <= 1'b0;
			end
			pend_q <= issue;
			if (pend_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid) begin
			idx_q   <= '0;
			len_q   <= frame.len[LW-1:0];
			empty_q <= (frame.len == '0);
			ctrl_q  <= frame.ctrl;
			cmd_q   <= frame.cmd;
			hb_q    <= frame.hb;
		end else if (issue) begin
			idx_q <= idx_nxt[LW-1:0];
		end
		if (issue) begin
			pend_idx_s1  <= idx_q;
			pend_last_s1 <= at_last;
		end
		if (pend_q) begin
			ctrl_code      <= ctrl_q;
			cmd_code       <= cmd_q;
			payload_length <= len_w[5:0];
			byte_index     <= idx_w[4:0];
			payload_byte   <= empty_q ? 8'd0 : rd_data;
			has_payload    <= !empty_q;
			is_heartbeat   <= hb_q;
			last_of_frame  <= pend_last_s1;
		end
	end

endmodule
